>>> hdl/tla_pkg.sv
`default_nettype none

package tla_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int ROW_IDX_W = $clog2(MAX_ROWS);
   localparam int COL_IDX_W = $clog2(MAX_COLS);
   localparam int SIZE_W    = 7;
   localparam int CSR_ADR_W = 1;

   localparam logic [CSR_ADR_W-1:0] REG_GRID_ROWS = 1'd0;
   localparam logic [CSR_ADR_W-1:0] REG_GRID_COLS = 1'd1;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_READ    = 2'd1;
   localparam logic [1:0] ACT_ADVANCE = 2'd2;

   typedef logic [MAX_COLS-1:0] row_type;

   typedef struct packed {
      logic                 shift;
      logic                 load;
      logic                 wr_en;
      logic [COL_IDX_W-1:0] wr_col;
      logic                 wr_val;
   } cell_ctrl_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] reg_val,
                                                  input logic [SIZE_W-1:0] max_val);
      if (reg_val == '0) begin
         return SIZE_W'(1);
      end else if (reg_val > max_val) begin
         return max_val;
      end
      return reg_val;
   endfunction

endpackage

`default_nettype wire

>>> hdl/tla_row_cell.sv
`default_nettype none

module tla_row_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tla_pkg::cell_ctrl_type ctrl,
   input  wire tla_pkg::row_type       up_row,
   input  wire tla_pkg::row_type       new_row,
   output tla_pkg::row_type            row_q
);
   import tla_pkg::*;

   row_type row_ff;
   row_type row_in;

   always_comb begin
      row_in = row_ff;
      if (ctrl.load) begin
         row_in = new_row;
      end else if (ctrl.shift) begin
         row_in = up_row;
      end else if (ctrl.wr_en) begin
         row_in[ctrl.wr_col] = ctrl.wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_q = row_ff;

endmodule

`default_nettype wire

>>> hdl/tla_row_rule.sv
`default_nettype none

module tla_row_rule (
   input  wire tla_pkg::row_type                 prev_row,
   input  wire tla_pkg::row_type                 cur_row,
   input  wire tla_pkg::row_type                 next_row,
   input  wire logic [tla_pkg::SIZE_W-1:0]       num_cols,
   output tla_pkg::row_type                      new_row
);
   import tla_pkg::*;

   logic [COL_IDX_W-1:0] last;

   assign last = num_cols[COL_IDX_W-1:0] - COL_IDX_W'(1);

   always_comb begin
      logic [2:0] lft;
      logic [2:0] rgt;
      logic [3:0] cnt;
      lft = '0;
      rgt = '0;
      cnt = '0;
      new_row = cur_row;
      for (int c = 0; c < MAX_COLS; c++) begin
         if (c == 0) begin
            lft = {prev_row[last], cur_row[last], next_row[last]};
         end else begin
            lft = {prev_row[(c + MAX_COLS - 1) % MAX_COLS],
                   cur_row[(c + MAX_COLS - 1) % MAX_COLS],
                   next_row[(c + MAX_COLS - 1) % MAX_COLS]};
         end
         if (COL_IDX_W'(c) == last) begin
            rgt = {prev_row[0], cur_row[0], next_row[0]};
         end else begin
            rgt = {prev_row[(c + 1) % MAX_COLS], cur_row[(c + 1) % MAX_COLS],
                   next_row[(c + 1) % MAX_COLS]};
         end
         cnt = 4'(lft[0]) + 4'(lft[1]) + 4'(lft[2]) + 4'(rgt[0]) + 4'(rgt[1])
             + 4'(rgt[2]) + 4'(prev_row[c]) + 4'(next_row[c]);
         if (SIZE_W'(c) < num_cols) begin
            new_row[c] = cur_row[c] ? (cnt == 4'd2 || cnt == 4'd3) : (cnt == 4'd3);
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/toroidal_life_automaton_unit.sv
// A B3/S23 life grid on a torus of up to 64 by 64 cells, held as a ring of row
// cells. A write, read or empty request gives its response in the cycle after it
// is accepted. An advance request rotates the active rows once around the ring,
// one row per cycle, while a rule unit builds each new row from the row and its
// two neighbors; its response follows once the rotation is done.
`default_nettype none

module toroidal_life_automaton_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [15:0]                   req_tdata,  // row, col, value
   input  wire logic [1:0]                    req_tuser,  // action
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [7:0]                         rsp_tdata,  // cell_value
   output logic [0:0]                         rsp_tuser,  // generation_done
   input  wire logic                          csr_we,
   input  wire logic [tla_pkg::CSR_ADR_W-1:0] csr_addr,
   input  wire logic [tla_pkg::SIZE_W-1:0]    csr_wdata
);
   import tla_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_type;

   state_type            state_ff;
   logic [SIZE_W-1:0]    rows_ff, cols_ff, nr_ff, nc_ff;
   logic [ROW_IDX_W-1:0] k_ff;
   row_type              prev_ff, row0_ff;
   logic                 rsp_valid_ff, rsp_cell_ff, rsp_done_ff;

   row_type              row_q [MAX_ROWS];
   row_type              new_row, next_row;
   logic [ROW_IDX_W-1:0] in_row;
   logic [COL_IDX_W-1:0] in_col;
   logic [SIZE_W-1:0]    nr_eff, nc_eff;
   logic                 out_free, fire, in_area, run_step, last_step, rsp_set;
   logic [ROW_IDX_W-1:0] top_idx;

   assign in_row    = req_tdata[ROW_IDX_W-1:0];
   assign in_col    = req_tdata[ROW_IDX_W +: COL_IDX_W];
   assign nr_eff    = eff_size(rows_ff, SIZE_W'(MAX_ROWS));
   assign nc_eff    = eff_size(cols_ff, SIZE_W'(MAX_COLS));
   assign in_area   = (SIZE_W'(in_row) < nr_eff) && (SIZE_W'(in_col) < nc_eff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign fire      = req_tvalid && req_tready;
   assign run_step  = (state_ff == S_RUN);
   assign top_idx   = nr_ff[ROW_IDX_W-1:0] - ROW_IDX_W'(1);
   assign last_step = (k_ff == top_idx);
   assign next_row  = last_step ? row0_ff : row_q[1];
   assign rsp_set   = (fire && (req_tuser != ACT_ADVANCE))
                      || ((state_ff == S_DONE) && out_free);

   for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cells
      cell_ctrl_type ctrl;
      row_type       up_row;
      assign ctrl.load   = run_step && (ROW_IDX_W'(i) == top_idx);
      assign ctrl.shift  = run_step && (SIZE_W'(i) < nr_ff);
      assign ctrl.wr_en  = fire && (req_tuser == ACT_WRITE) && in_area
                           && (in_row == ROW_IDX_W'(i));
      assign ctrl.wr_col = in_col;
      assign ctrl.wr_val = req_tdata[ROW_IDX_W + COL_IDX_W];
      if (i < MAX_ROWS - 1) begin : g_up
         assign up_row = row_q[i+1];
      end else begin : g_top
         assign up_row = '0;
      end
      tla_row_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .up_row  (up_row),
         .new_row (new_row),
         .row_q   (row_q[i])
      );
   end

   tla_row_rule u_rule (
      .prev_row (prev_ff),
      .cur_row  (row_q[0]),
      .next_row (next_row),
      .num_cols (nc_ff),
      .new_row  (new_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rows_ff      <= SIZE_W'(MAX_ROWS);
         cols_ff      <= SIZE_W'(MAX_COLS);
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         if (csr_we && csr_addr == REG_GRID_ROWS) begin
            rows_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == REG_GRID_COLS) begin
            cols_ff <= csr_wdata;
         end
         if (rsp_set) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (fire) begin
                  rsp_cell_ff <= (req_tuser == ACT_READ && in_area) ?
                                 row_q[in_row][in_col] : 1'b0;
                  rsp_done_ff <= 1'b0;
                  if (req_tuser == ACT_ADVANCE) begin
                     state_ff <= S_RUN;
                     nr_ff    <= nr_eff;
                     nc_ff    <= nc_eff;
                     k_ff     <= '0;
                     prev_ff  <= row_q[nr_eff[ROW_IDX_W-1:0] - ROW_IDX_W'(1)];
                     row0_ff  <= row_q[0];
                  end
               end
            end
            S_RUN: begin
               prev_ff <= row_q[0];
               k_ff    <= k_ff + ROW_IDX_W'(1);
               if (last_step) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_done_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cell_ff};
   assign rsp_tuser  = rsp_done_ff;

`ifndef SYNTH
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tdata[0]))
      else $error("read value and generation done both set");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (SIZE_W'(k_ff) < nr_ff))
      else $error("generation step beyond active rows");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |=> !(req_tvalid && req_tready) || (state_ff == S_IDLE))
      else $error("request accepted during a generation");
`endif

endmodule

`default_nettype wire

>>> tb/tla_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module tla_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   input  wire logic                          req_tready,
   input  wire logic [15:0]                   req_tdata,
   input  wire logic [1:0]                    req_tuser,
   input  wire logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   input  wire logic [7:0]                    rsp_tdata,
   input  wire logic [0:0]                    rsp_tuser,
   input  wire logic                          csr_we,
   input  wire logic [tla_pkg::CSR_ADR_W-1:0] csr_addr,
   input  wire logic [tla_pkg::SIZE_W-1:0]    csr_wdata,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 advance_count,
   output int                                 live_reads
);
   import tla_pkg::*;

   typedef struct packed {
      logic [7:0] cell_value;
      logic       generation_done;
   } life_rsp_type;

   logic               cells [MAX_ROWS*MAX_COLS];
   logic               built [MAX_ROWS*MAX_COLS];
   logic [SIZE_W-1:0]  rows_reg;
   logic [SIZE_W-1:0]  cols_reg;
   life_rsp_type       expected_rsps [$];

   function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return int'(v);
   endfunction

   task automatic step_generation();
      int nr, nc, live, rr, cc;
      nr = clamp_size(rows_reg, MAX_ROWS);
      nc = clamp_size(cols_reg, MAX_COLS);
      for (int r = 0; r < MAX_ROWS; r++) begin
         for (int c = 0; c < MAX_COLS; c++) begin
            if (r < nr && c < nc) begin
               live = 0;
               for (int dr = -1; dr <= 1; dr++) begin
                  for (int dc = -1; dc <= 1; dc++) begin
                     if (dr != 0 || dc != 0) begin
                        rr = (r + nr + dr) % nr;
                        cc = (c + nc + dc) % nc;
                        live += cells[rr*MAX_COLS + cc];
                     end
                  end
               end
               if (cells[r*MAX_COLS + c]) built[r*MAX_COLS + c] = (live == 2 || live == 3);
               else built[r*MAX_COLS + c] = (live == 3);
            end else begin
               built[r*MAX_COLS + c] = cells[r*MAX_COLS + c];
            end
         end
      end
      cells = built;
   endtask

   always @(posedge clock) begin
      logic [5:0]   row, col;
      logic         in_area;
      life_rsp_type exp_rsp, got;
      if (reset) begin
         foreach (cells[i]) cells[i] = 1'b0;
         rows_reg = 7'd64;
         cols_reg = 7'd64;
         expected_rsps.delete();
         fail_count <= 0;
         pending <= 0;
         advance_count <= 0;
         live_reads <= 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == REG_GRID_ROWS) rows_reg = csr_wdata;
            else if (csr_addr == REG_GRID_COLS) cols_reg = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tuser[0]};
            if (expected_rsps.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected response %p", got);
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (got !== exp_rsp) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10) $display("mismatch: expected %p, got %p", exp_rsp, got);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            row = req_tdata[5:0];
            col = req_tdata[11:6];
            in_area = row < clamp_size(rows_reg, MAX_ROWS) && col < clamp_size(cols_reg, MAX_COLS);
            exp_rsp = '0;
            case (req_tuser)
               ACT_WRITE: begin
                  if (in_area) cells[row*MAX_COLS + col] = req_tdata[12];
               end
               ACT_READ: begin
                  if (in_area) exp_rsp.cell_value = {7'd0, cells[row*MAX_COLS + col]};
                  if (exp_rsp.cell_value[0]) live_reads <= live_reads + 1;
               end
               ACT_ADVANCE: begin
                  step_generation();
                  exp_rsp.generation_done = 1'b1;
                  advance_count <= advance_count + 1;
               end
               default: ;
            endcase
            expected_rsps.push_back(exp_rsp);
         end
         pending <= expected_rsps.size();
      end
   end
endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none

module tb;
   import tla_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;
   logic [1:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic [0:0]           rsp_tuser;
   logic                 csr_we = 1'b0;
   logic [CSR_ADR_W-1:0] csr_addr = '0;
   logic [SIZE_W-1:0]    csr_wdata = '0;
   int                   fail_count, pending, advance_count, live_reads;
   int                   idle_cycles = 0;
   int                   request_count = 0;
   int                   sizes_used = 0;
   bit                   stall_random = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   toroidal_life_automaton_unit dut (.*);

   tla_checker checker_i (.*);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!stall_random) rsp_tready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) rsp_tready <= 1'b0;
      else if ($urandom_range(0, 3) != 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 9) == 0);
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic send(input logic [1:0] act, input int r, input int c, input bit v);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {3'b000, v, 6'(c), 6'(r)};
      do @(posedge clock); while (!req_tready);
      request_count++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0 || req_tvalid);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_size(input int rows, input int cols);
      drain();
      csr_we <= 1'b1;
      csr_addr <= REG_GRID_ROWS;
      csr_wdata <= 7'(rows);
      @(posedge clock);
      csr_addr <= REG_GRID_COLS;
      csr_wdata <= 7'(cols);
      @(posedge clock);
      csr_we <= 1'b0;
      sizes_used++;
   endtask

   task automatic random_phase(input int count, input int rows, input int cols);
      int rlim, clim;
      rlim = (rows == 0) ? 1 : (rows > 64 ? 64 : rows);
      clim = (cols == 0) ? 1 : (cols > 64 ? 64 : cols);
      set_size(rows, cols);
      for (int i = 0; i < count; i++) begin
         int k;
         k = $urandom_range(0, 19);
         if (k < 9)
            send(ACT_WRITE, $urandom_range(0, rlim - 1), $urandom_range(0, clim - 1),
                 $urandom_range(0, 2) != 0);
         else if (k < 15)
            send(ACT_READ, $urandom_range(0, rlim - 1), $urandom_range(0, clim - 1), 0);
         else if (k < 17) send(ACT_ADVANCE, $urandom, $urandom, 1'($urandom));
         else send(2'($urandom_range(0, 3)), $urandom, $urandom, 1'($urandom));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(ACT_READ, 0, 0, 0);
      send(ACT_READ, 63, 63, 0);
      send(ACT_WRITE, 63, 63, 1);
      send(ACT_READ, 63, 63, 0);
      send(ACT_WRITE, 0, 0, 1);
      send(ACT_WRITE, 0, 1, 1);
      send(ACT_WRITE, 0, 63, 1);
      send(ACT_ADVANCE, 0, 0, 0);
      send(ACT_READ, 63, 0, 0);
      send(ACT_READ, 1, 0, 0);
      send(2'd3, 63, 63, 1);
      send(ACT_READ, 0, 0, 0);
      stall_random = 1'b0;
      drain();
      stall_random = 1'b1;

      set_size(1, 1);
      send(ACT_WRITE, 0, 0, 1);
      send(ACT_WRITE, 5, 5, 0);
      send(ACT_READ, 5, 5, 0);
      send(ACT_ADVANCE, 0, 0, 0);
      send(ACT_READ, 0, 0, 0);
      set_size(0, 127);
      send(ACT_READ, 0, 63, 0);
      send(ACT_ADVANCE, 0, 0, 0);
      set_size(127, 0);
      send(ACT_READ, 63, 0, 0);

      random_phase(30, 4, 4);
      random_phase(25, 3, 7);
      random_phase(25, 64, 64);
      random_phase(20, 1, 5);
      random_phase(20, 6, 2);

      drain();
      $display("Covered %0d requests over %0d grid sizes, %0d generations, %0d live reads.",
               request_count, sizes_used, advance_count, live_reads);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

`default_nettype wire

>>> filelist.f
hdl/tla_pkg.sv
hdl/tla_row_cell.sv
hdl/tla_row_rule.sv
hdl/toroidal_life_automaton_unit.sv
tb/tla_checker.sv
tb/tb.sv
